// ===== hw/rtl/pis_pkg.sv =====
// shared types and constants for the pid controller with integral separation
`timescale 1ns / 1ps

package pis_pkg;

   localparam int FracBitsDefault    = 16;
   localparam int SampleWidthDefault = 16;

   localparam int GainWidth  = 32;
   localparam int DriveWidth = 32;
   localparam int LimitWidth = 17;
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = 32;
   localparam int AccWidth   = 64;

   typedef enum logic [1:0] {
      MODE_SPEED = 2'd0,
      MODE_ANGLE = 2'd1,
      MODE_INCR  = 2'd2,
      MODE_SPARE = 2'd3
   } mode_type;

   typedef enum logic [CsrIdxW-1:0] {
      REG_MODE   = 3'd0,
      REG_GAIN_P = 3'd1,
      REG_GAIN_I = 3'd2,
      REG_GAIN_D = 3'd3,
      REG_SEP    = 3'd4,
      REG_RSVD5  = 3'd5,
      REG_RSVD6  = 3'd6,
      REG_RSVD7  = 3'd7
   } csr_idx_type;

   localparam logic [LimitWidth-1:0] SepLimitReset = 17'h1FFFF;

   // integral accumulator rails, +-2^61
   localparam logic signed [AccWidth-1:0] IntegMax = 64'sh2000_0000_0000_0000;
   localparam logic signed [AccWidth-1:0] IntegMin = -64'sh2000_0000_0000_0000;

   localparam logic signed [AccWidth-1:0] Max32 = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [AccWidth-1:0] Min32 = -64'sh0000_0000_8000_0000;
   localparam logic signed [AccWidth-1:0] Max16 = 64'sh0000_0000_0000_7FFF;
   localparam logic signed [AccWidth-1:0] Min16 = -64'sh0000_0000_0000_8000;

endpackage

// ===== hw/rtl/pid_integral_separation.sv =====
// top level of the pid controller with integral separation
`timescale 1ns / 1ps

// PID controller with integral separation, fixed point.
// A request carries a set point and a feedback sample (req_ channel, valid/ready).
// Each request produces exactly one response on the rsp_ channel: the drive value,
// truncated toward zero and saturated, and a flag that says it was clipped.
// Mode, gains (signed Q16.16) and the separation limit are written through the
// csr_ channel, which is always ready; write it only while no request is in flight.
// A request is taken into one input register; from there the three gain multipliers,
// the sum and the saturation feed the response register. Throughput is one request
// per cycle while rsp_ready stays high; the integral and error history update in the
// same cycle the response register loads, so the next request sees them at once.
// A held response does not block the input register: a new request is taken while
// the response waits, and only when both registers are full and rsp_ready is low
// does req_ready drop.
// Synchronous reset clears the pipeline, the history, the integral and the
// configuration (separation limit to its maximum, everything else to zero).

module pid_integral_separation #(
   parameter int FRAC_BITS    = pis_pkg::FracBitsDefault,
   parameter int SAMPLE_WIDTH = pis_pkg::SampleWidthDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_target_value,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_measured_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pis_pkg::DriveWidth-1:0] rsp_drive,
   output logic                                rsp_clipped,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pis_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [pis_pkg::CsrDataW-1:0]        csr_wdata
);

   localparam int ERR_W   = SAMPLE_WIDTH + 1;
   localparam int DIFF_W  = SAMPLE_WIDTH + 2;
   localparam int DIFF2_W = SAMPLE_WIDTH + 3;
   localparam int PROD_W  = pis_pkg::GainWidth + DIFF2_W;
   localparam int ACC_W   = pis_pkg::AccWidth;
   localparam logic signed [ACC_W-1:0] RoundBias = ACC_W'((64'sd1 <<< FRAC_BITS) - 64'sd1);

   // configuration
   pis_pkg::mode_type                     mode_ff;
   logic signed [pis_pkg::GainWidth-1:0]  gain_p_ff;
   logic signed [pis_pkg::GainWidth-1:0]  gain_i_ff;
   logic signed [pis_pkg::GainWidth-1:0]  gain_d_ff;
   logic [pis_pkg::LimitWidth-1:0]        sep_lim_ff;

   // pipeline
   logic                           in_vld_ff;
   logic signed [SAMPLE_WIDTH-1:0] in_tgt_ff;
   logic signed [SAMPLE_WIDTH-1:0] in_meas_ff;
   logic                           out_vld_ff;
   logic signed [pis_pkg::DriveWidth-1:0] out_drive_ff;
   logic                           out_clip_ff;
   logic signed [pis_pkg::DriveWidth-1:0] out_drive_in;
   logic                           out_clip_in;

   // controller state
   logic signed [ACC_W-1:0] integ_ff;
   logic signed [ACC_W-1:0] integ_in;
   logic signed [ERR_W-1:0] prev_err_ff;
   logic signed [ERR_W-1:0] pprev_err_ff;
   logic signed [ERR_W-1:0] pprev_err_in;

   logic advance;
   logic req_take;

   // datapath
   logic signed [ERR_W-1:0]   err;
   logic [ERR_W-1:0]          err_mag;
   logic signed [DIFF_W-1:0]  diff1;
   logic signed [DIFF2_W-1:0] diff2;
   logic signed [DIFF2_W-1:0] p_opd;
   logic signed [DIFF2_W-1:0] d_opd;
   logic signed [PROD_W-1:0]  prod_p;
   logic signed [PROD_W-1:0]  prod_i;
   logic signed [PROD_W-1:0]  prod_d;
   logic signed [ACC_W-1:0]   integ_acc;
   logic signed [ACC_W-1:0]   sum;
   logic signed [ACC_W-1:0]   quot;
   logic signed [ACC_W-1:0]   hi_rail;
   logic signed [ACC_W-1:0]   lo_rail;
   logic                      is_incr;
   logic                      is_angle;

   assign advance   = !out_vld_ff || rsp_ready;
   assign req_ready = !in_vld_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid   = out_vld_ff;
   assign rsp_drive   = out_drive_ff;
   assign rsp_clipped = out_clip_ff;

   always_comb begin
      is_incr  = 1'b0;
      is_angle = 1'b0;
      unique case (mode_ff)
         pis_pkg::MODE_INCR:  is_incr  = 1'b1;
         pis_pkg::MODE_ANGLE: is_angle = 1'b1;
         default:             ;
      endcase
   end

   always_comb begin
      err     = ERR_W'(in_tgt_ff) - ERR_W'(in_meas_ff);
      err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
      diff1   = DIFF_W'(err) - DIFF_W'(prev_err_ff);
      diff2   = DIFF2_W'(err) - (DIFF2_W'(prev_err_ff) <<< 1) + DIFF2_W'(pprev_err_ff);

      // derivative sign folded into its operand
      p_opd = is_incr ? DIFF2_W'(diff1) : DIFF2_W'(err);
      if (is_incr) begin
         d_opd = diff2;
      end else if (is_angle) begin
         d_opd = -DIFF2_W'(in_meas_ff);
      end else begin
         d_opd = -DIFF2_W'(diff1);
      end

      prod_p = PROD_W'(gain_p_ff) * PROD_W'(p_opd);
      prod_i = PROD_W'(gain_i_ff) * PROD_W'(err);
      prod_d = PROD_W'(gain_d_ff) * PROD_W'(d_opd);

      integ_acc = integ_ff + ACC_W'(prod_i);
      if (is_incr) begin
         integ_in = ACC_W'(prod_i);
      end else if (32'(err_mag) > 32'(sep_lim_ff)) begin
         integ_in = '0;
      end else if (integ_acc > pis_pkg::IntegMax) begin
         integ_in = pis_pkg::IntegMax;
      end else if (integ_acc < pis_pkg::IntegMin) begin
         integ_in = pis_pkg::IntegMin;
      end else begin
         integ_in = integ_acc;
      end

      pprev_err_in = is_incr ? prev_err_ff : pprev_err_ff;

      sum = ACC_W'(prod_p) + integ_in + ACC_W'(prod_d);
      // truncate toward zero
      quot = (sum[ACC_W-1] ? sum + RoundBias : sum) >>> FRAC_BITS;

      if (is_incr || is_angle) begin
         hi_rail = pis_pkg::Max32;
         lo_rail = pis_pkg::Min32;
      end else begin
         hi_rail = pis_pkg::Max16;
         lo_rail = pis_pkg::Min16;
      end

      priority if (quot > hi_rail) begin
         out_drive_in = pis_pkg::DriveWidth'(hi_rail);
         out_clip_in  = 1'b1;
      end else if (quot < lo_rail) begin
         out_drive_in = pis_pkg::DriveWidth'(lo_rail);
         out_clip_in  = 1'b1;
      end else begin
         out_drive_in = pis_pkg::DriveWidth'(quot);
         out_clip_in  = 1'b0;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= pis_pkg::MODE_SPEED;
         gain_p_ff  <= '0;
         gain_i_ff  <= '0;
         gain_d_ff  <= '0;
         sep_lim_ff <= pis_pkg::SepLimitReset;
      end else if (csr_valid && csr_ready) begin
         unique case (pis_pkg::csr_idx_type'(csr_index))
            pis_pkg::REG_MODE:   mode_ff    <= pis_pkg::mode_type'(csr_wdata[1:0]);
            pis_pkg::REG_GAIN_P: gain_p_ff  <= pis_pkg::GainWidth'(csr_wdata);
            pis_pkg::REG_GAIN_I: gain_i_ff  <= pis_pkg::GainWidth'(csr_wdata);
            pis_pkg::REG_GAIN_D: gain_d_ff  <= pis_pkg::GainWidth'(csr_wdata);
            pis_pkg::REG_SEP:    sep_lim_ff <= csr_wdata[pis_pkg::LimitWidth-1:0];
            default:             ;
         endcase
      end
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         integ_ff     <= '0;
         prev_err_ff  <= '0;
         pprev_err_ff <= '0;
      end else begin
         if (req_take) begin
            in_vld_ff <= 1'b1;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         if (advance) begin
            out_vld_ff <= in_vld_ff;
         end
         if (advance && in_vld_ff) begin
            integ_ff     <= integ_in;
            prev_err_ff  <= err;
            pprev_err_ff <= pprev_err_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_tgt_ff  <= req_target_value;
         in_meas_ff <= req_measured_value;
      end
      if (advance && in_vld_ff) begin
         out_drive_ff <= out_drive_in;
         out_clip_ff  <= out_clip_in;
      end
   end

   // a clipped response sits on one of the rails
   a_clip_on_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         (ACC_W'(rsp_drive) == pis_pkg::Max32) || (ACC_W'(rsp_drive) == pis_pkg::Min32) ||
         (ACC_W'(rsp_drive) == pis_pkg::Max16) || (ACC_W'(rsp_drive) == pis_pkg::Min16))
      else $error("clipped response not on a rail");

   // accumulator stays inside its rails
   a_integ_bound: assert property (@(posedge clock) disable iff (reset)
      (integ_ff <= pis_pkg::IntegMax) && (integ_ff >= pis_pkg::IntegMin))
      else $error("integral out of range");

   // history moves only when a request is processed
   a_hist_hold: assert property (@(posedge clock) disable iff (reset)
      !(advance && in_vld_ff) |=> $stable(prev_err_ff) && $stable(integ_ff))
      else $error("controller state changed without a request");

   // pipeline empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the pid controller with integral separation
`timescale 1ns / 1ps

module tb;

   localparam int SampleW    = pis_pkg::SampleWidthDefault;
   localparam int FracW      = pis_pkg::FracBitsDefault;
   localparam int HoldCycles = 300;
   localparam int DrainLimit = 200000;
   localparam int RandPhases = 12;
   localparam int PhaseItems = 66;

   typedef struct packed {
      logic signed [SampleW-1:0] target;
      logic signed [SampleW-1:0] measured;
   } sample_type;

   typedef struct packed {
      logic signed [pis_pkg::DriveWidth-1:0] drive;
      logic                                  clipped;
   } drive_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                  req_valid          = 1'b0;
   logic                                  req_ready;
   logic signed [SampleW-1:0]             req_target_value   = '0;
   logic signed [SampleW-1:0]             req_measured_value = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready          = 1'b0;
   logic signed [pis_pkg::DriveWidth-1:0] rsp_drive;
   logic                                  rsp_clipped;
   logic                                  csr_valid          = 1'b0;
   logic                                  csr_ready;
   logic [pis_pkg::CsrIdxW-1:0]           csr_index          = '0;
   logic [pis_pkg::CsrDataW-1:0]          csr_wdata          = '0;

   pid_integral_separation dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_target_value   (req_target_value),
      .req_measured_value (req_measured_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive          (rsp_drive),
      .rsp_clipped        (rsp_clipped),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #10 clock = ~clock;

   // controller settings and history as the block should hold them
   pis_pkg::mode_type cfg_mode  = pis_pkg::MODE_SPEED;
   longint            k_p       = 0;
   longint            k_i       = 0;
   longint            k_d       = 0;
   longint            sep_lim   = longint'(pis_pkg::SepLimitReset);
   longint            integ_acc = 0;
   longint            err_1     = 0;
   longint            err_2     = 0;

   sample_type sample_q[$];
   drive_type  expected_drives[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cnt = 0;
   bit hold_arm = 1'b0;
   bit hold_taken = 1'b0;

   int mismatches = 0;
   int n_requests = 0;
   int n_responses = 0;
   int n_clipped = 0;
   int n_stall = 0;
   int n_settings = 0;

   function automatic drive_type compute_drive(logic signed [SampleW-1:0] tgt,
                                               logic signed [SampleW-1:0] meas);
      longint e, mag, p, d, sum, val, lo, hi;
      drive_type r;
      e = longint'(tgt) - longint'(meas);
      if (cfg_mode == pis_pkg::MODE_INCR) begin
         p = k_p * (e - err_1);
         integ_acc = k_i * e;
         d = k_d * (e - 2 * err_1 + err_2);
         err_2 = err_1;
         lo = pis_pkg::Min32;
         hi = pis_pkg::Max32;
      end else begin
         mag = (e < 0) ? -e : e;
         p = k_p * e;
         integ_acc = integ_acc + k_i * e;
         if (integ_acc > pis_pkg::IntegMax) integ_acc = pis_pkg::IntegMax;
         if (integ_acc < pis_pkg::IntegMin) integ_acc = pis_pkg::IntegMin;
         // separation: drop the integral on a large error
         if (mag > sep_lim) integ_acc = 0;
         if (cfg_mode == pis_pkg::MODE_ANGLE) begin
            d = -(k_d * longint'(meas));
            lo = pis_pkg::Min32;
            hi = pis_pkg::Max32;
         end else begin
            d = -(k_d * (e - err_1));
            lo = pis_pkg::Min16;
            hi = pis_pkg::Max16;
         end
      end
      err_1 = e;
      sum = p + integ_acc + d;
      // truncate toward zero
      val = (sum < 0) ? -((-sum) >>> FracW) : (sum >>> FracW);
      r.clipped = 1'b0;
      if (val > hi) begin
         val = hi;
         r.clipped = 1'b1;
      end else if (val < lo) begin
         val = lo;
         r.clipped = 1'b1;
      end
      r.drive = val[pis_pkg::DriveWidth-1:0];
      return r;
   endfunction

   task automatic flag(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch: %s expected %0d got %0d at %0t", what, want, got, $realtime);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_drives.push_back(compute_drive(req_target_value, req_measured_value));
            n_requests++;
         end
         if (req_valid && !req_ready) begin
            n_stall++;
         end else if (sample_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_valid          <= 1'b1;
            req_target_value   <= sample_q[0].target;
            req_measured_value <= sample_q[0].measured;
            void'(sample_q.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt <= 0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (hold_arm && !hold_taken) begin
         hold_cnt   <= HoldCycles;
         hold_taken <= 1'b1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      drive_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_responses++;
            if (rsp_clipped) n_clipped++;
            if (expected_drives.size() == 0) begin
               flag("unexpected response drive", 0, rsp_drive);
            end else begin
               want = expected_drives.pop_front();
               if (rsp_drive !== want.drive) flag("drive", want.drive, rsp_drive);
               if (rsp_clipped !== want.clipped) flag("clipped", want.clipped, rsp_clipped);
            end
         end
         rsp_ready <= (hold_cnt == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   task automatic write_csr(pis_pkg::csr_idx_type idx, logic [pis_pkg::CsrDataW-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         pis_pkg::REG_MODE:   cfg_mode = pis_pkg::mode_type'(val[1:0]);
         pis_pkg::REG_GAIN_P: k_p = longint'($signed(val));
         pis_pkg::REG_GAIN_I: k_i = longint'($signed(val));
         pis_pkg::REG_GAIN_D: k_d = longint'($signed(val));
         pis_pkg::REG_SEP:    sep_lim = longint'({1'b0, val[pis_pkg::LimitWidth-1:0]});
         default: ;
      endcase
   endtask

   // unused upper bits of mode and limit writes carry noise
   task automatic load_config(pis_pkg::mode_type m, logic [31:0] kp, logic [31:0] ki,
                              logic [31:0] kd, logic [pis_pkg::LimitWidth-1:0] sep);
      logic [pis_pkg::CsrDataW-1:0] mval, sval;
      mval = $urandom();
      mval[1:0] = m;
      sval = $urandom();
      sval[pis_pkg::LimitWidth-1:0] = sep;
      write_csr(pis_pkg::REG_MODE, mval);
      write_csr(pis_pkg::REG_GAIN_P, kp);
      write_csr(pis_pkg::REG_GAIN_I, ki);
      write_csr(pis_pkg::REG_GAIN_D, kd);
      write_csr(pis_pkg::REG_SEP, sval);
      n_settings++;
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      @(negedge clock);
      while ((sample_q.size() != 0 || req_valid || expected_drives.size() != 0)
             && waited < DrainLimit) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic push_many(int n, logic signed [SampleW-1:0] t, logic signed [SampleW-1:0] m);
      sample_type s;
      s.target = t;
      s.measured = m;
      repeat (n) sample_q.push_back(s);
   endtask

   function automatic logic [31:0] rand_gain();
      logic [31:0] picks[5];
      picks = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'hFFFF_0000};
      case ($urandom_range(3, 0))
         0: return $urandom();
         1: return 32'($urandom_range(32'h8_0000, 0)) - 32'h4_0000;
         2: return 32'($urandom_range(32'h2000, 0)) - 32'h1000;
         default: return picks[$urandom_range(4, 0)];
      endcase
   endfunction

   function automatic sample_type rand_sample();
      sample_type s;
      longint t, m, dlt, lo, hi;
      int kind;
      logic signed [SampleW-1:0] edges[5];
      edges = '{16'sh8000, 16'sh7FFF, 16'sh0, -16'sh1, 16'sh1};
      kind = $urandom_range(9, 0);
      t = longint'($signed(16'($urandom())));
      m = longint'($signed(16'($urandom())));
      if (kind <= 5) begin
         // feedback tracking the set point closely
         m = t + longint'($urandom_range(400, 0)) - 200;
         if (m > 32767) m = 32767;
         if (m < -32768) m = -32768;
      end else if (kind == 8) begin
         t = longint'(edges[$urandom_range(4, 0)]);
         m = longint'(edges[$urandom_range(4, 0)]);
      end else if (kind == 9) begin
         // error right at or just past the separation limit
         dlt = sep_lim + longint'($urandom_range(1, 0));
         if ($urandom_range(1, 0) == 1) dlt = -dlt;
         if (dlt > 65535 || dlt < -65535) dlt = 0;
         lo = (dlt > 0) ? -32768 + dlt : -32768;
         hi = (dlt > 0) ? 32767 : 32767 + dlt;
         t = lo + longint'($urandom_range(32'(hi - lo), 0));
         m = t - dlt;
      end
      s.target = t[SampleW-1:0];
      s.measured = m[SampleW-1:0];
      return s;
   endfunction

   initial begin
      logic [pis_pkg::LimitWidth-1:0] sep;
      logic [31:0] sr;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: separation boundary and 16-bit saturation in speed mode
      load_config(pis_pkg::MODE_SPEED, 32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 17'd100);
      @(negedge clock);
      push_many(1, 16'sd0, 16'sd0);
      push_many(1, 16'sd100, 16'sd0);
      push_many(1, 16'sd0, 16'sd101);
      push_many(1, 16'sh7FFF, 16'sh8000);
      push_many(1, 16'sh8000, 16'sh7FFF);
      push_many(1, 16'sd5, 16'sd5);
      drain();
      // angle mode, extreme gains, zero limit
      load_config(pis_pkg::MODE_ANGLE, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 17'd0);
      @(negedge clock);
      push_many(1, 16'sh7FFF, 16'sh8000);
      push_many(1, 16'sh8000, 16'sh7FFF);
      push_many(1, 16'sd0, 16'sh8000);
      push_many(1, 16'sd1, 16'sd0);
      drain();
      load_config(pis_pkg::MODE_INCR, 32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000, 17'h1FFFF);
      @(negedge clock);
      push_many(1, 16'sd10, 16'sd0);
      push_many(1, -16'sd20, 16'sd0);
      push_many(1, 16'sh7FFF, 16'sh8000);
      push_many(1, 16'sh8000, 16'sh7FFF);
      push_many(1, 16'sd0, 16'sd0);
      drain();
      // spare mode code acts as speed, integral carried over from incremental
      load_config(pis_pkg::MODE_SPARE, 32'h0000_8000, 32'h0000_2000, 32'h0001_0000, 17'd3000);
      write_csr(pis_pkg::REG_RSVD5, $urandom());
      @(negedge clock);
      push_many(1, 16'sd1000, -16'sd1000);
      push_many(1, 16'sd0, 16'sd0);
      push_many(1, -16'sd5, 16'sd7);
      drain();

      // long integral build-up one way, then swung back the other way
      load_config(pis_pkg::MODE_ANGLE, 32'h0, 32'h7FFF_FFFF, 32'h0, 17'h1FFFF);
      @(negedge clock);
      push_many(60, 16'sh7FFF, 16'sh8000);
      push_many(120, 16'sh8000, 16'sh7FFF);
      drain();

      for (int ph = 0; ph < RandPhases; ph++) begin
         sr = $urandom();
         case ($urandom_range(2, 0))
            0: sep = sr[pis_pkg::LimitWidth-1:0];
            1: sep = pis_pkg::LimitWidth'($urandom_range(2000, 0));
            default: sep = ($urandom_range(1, 0) == 1) ? pis_pkg::SepLimitReset : '0;
         endcase
         load_config(pis_pkg::mode_type'($urandom_range(3, 0)), rand_gain(), rand_gain(),
                     rand_gain(), sep);
         @(negedge clock);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase
         // fill the pipe against a receiver that stops taking responses
         if (ph == 4) hold_arm = 1'b1;
         for (int k = 0; k < PhaseItems; k++) begin
            sample_q.push_back(rand_sample());
            // sender pause until the block has delivered everything
            if (ph == 5 && k == PhaseItems / 2) begin
               drain();
            end
         end
         drain();
      end

      $display("checked %0d requests and %0d responses across %0d settings, %0d saturated",
               n_requests, n_responses, n_settings, n_clipped);
      $display("all four mode codes, long integral swings, %0d cycles of input back pressure",
               n_stall);
      while (expected_drives.size() != 0) begin
         flag("missing response drive", expected_drives[0].drive, 0);
         void'(expected_drives.pop_front());
      end
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/pis_pkg.sv
hw/rtl/pid_integral_separation.sv
verif/tb.sv
